[sv/image_mean_squared_error_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the image mean squared error block.
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IMAGE_MEAN_SQUARED_ERROR_MACROS_SVH
`define IMAGE_MEAN_SQUARED_ERROR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define IMSE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imse check failed");

// Next-cycle implication, checked outside reset.
`define IMSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imse check failed");

`else

`define IMSE_ASSERT_NOW(label, clk, rst, ante, cons)
`define IMSE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/imse_pkg.sv]
// ----------------------------------------------------------------------------
// imse_pkg
// Types, widths and helpers shared by the mean squared error modules.
// ----------------------------------------------------------------------------
`default_nettype none

package imse_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned SQ_W     = 2 * CH_W;
  localparam int unsigned ADD_W    = SQ_W + 2;
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned CNT_W    = 25;
  localparam int unsigned ERR_W    = 24;
  localparam int unsigned DIVR_W   = CNT_W + 2;
  localparam int unsigned REM_W    = DIVR_W + 1;
  localparam int unsigned SCALE_W  = 8;
  localparam int unsigned HI_W     = SUM_W + SCALE_W - ERR_W;
  localparam int unsigned STEP_W   = 5;
  localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(25'd16777216);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ERR_W - 1);

  typedef struct packed {
    logic [CH_W-1:0] test_red;
    logic [CH_W-1:0] test_green;
    logic [CH_W-1:0] test_blue;
    logic [CH_W-1:0] ref_red;
    logic [CH_W-1:0] ref_green;
    logic [CH_W-1:0] ref_blue;
    logic            last_pixel;
  } pixel_pair_t;

  typedef struct packed {
    logic [ERR_W-1:0] error_value;
    logic [CNT_W-1:0] pixels_seen;
  } mse_result_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Squared absolute difference of two channel samples.
  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {{CH_W{1'b0}}, d} * {{CH_W{1'b0}}, d};
  endfunction

endpackage

`default_nettype wire

[sv/imse_ctrl.sv]
// ----------------------------------------------------------------------------
// imse_ctrl
// Sequencer: pixel intake, final accumulate, divider run and result load.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_mean_squared_error_macros.svh"

module imse_ctrl
  import imse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pixel_valid,
  input  wire logic       pixel_last,
  input  wire dp_status_t status,
  output      ctrl_cmd_t  cmd,
  output      logic       pixel_ready
);

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    pixel_ready   = 1'b0;
    unique case (state)
      S_ACC: begin
        pixel_ready = 1'b1;
        cmd.accept  = pixel_valid;
        if (pixel_valid && pixel_last) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        step_next     = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LAST_STEP) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  `IMSE_ASSERT_NEXT(a_last_closes_intake, clk, rst, cmd.accept && pixel_last,
                    state == S_SUM)
  `IMSE_ASSERT_NOW(a_steps_in_range, clk, rst, cmd.div_step, step <= LAST_STEP)

endmodule

`default_nettype wire

[sv/imse_dp.sv]
// ----------------------------------------------------------------------------
// imse_dp
// Squared difference stage, accumulator, restoring divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_mean_squared_error_macros.svh"

module imse_dp
  import imse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  input  wire pixel_pair_t pixel,
  input  wire logic        result_stall,
  output      dp_status_t  status,
  output      mse_result_t result,
  output      logic        result_valid
);

  logic               s1_valid;
  logic [ADD_W-1:0]   s1_add;
  logic [SUM_W-1:0]   squared_sum;
  logic [CNT_W-1:0]   pixel_count;
  logic [REM_W-1:0]   rem;
  logic [ERR_W-1:0]   dvd_lo;
  logic [DIVR_W-1:0]  divisor;
  logic [ERR_W-1:0]   quot;
  logic [CNT_W-1:0]   seen;
  logic [REM_W-1:0]   trial;
  logic               fits;

  assign trial           = {rem[REM_W-2:0], dvd_lo[ERR_W-1]};
  assign fits            = trial >= {1'b0, divisor};
  assign status.out_free = !result_valid || !result_stall;

  // Squared differences of one pixel, registered ahead of the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.accept;
    end
    if (cmd.accept) begin
      s1_add <= ADD_W'(sq_diff(pixel.test_red, pixel.ref_red))
              + ADD_W'(sq_diff(pixel.test_green, pixel.ref_green))
              + ADD_W'(sq_diff(pixel.test_blue, pixel.ref_blue));
    end
  end

  // Accumulator; pixels beyond the limit are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      squared_sum <= '0;
      pixel_count <= '0;
    end else begin
      if (cmd.div_start) begin
        squared_sum <= '0;
        pixel_count <= '0;
      end else if (s1_valid && (pixel_count < MAX_PIXELS)) begin
        squared_sum <= squared_sum + SUM_W'(s1_add);
        pixel_count <= pixel_count + 1'b1;
      end
    end
  end

  // Restoring division of sum*256 by 3*count, one quotient bit per cycle.
  // The quotient is known to fit in ERR_W bits, so the upper dividend bits
  // start out already below the divisor.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= REM_W'(squared_sum[SUM_W-1:SUM_W-HI_W]);
      dvd_lo  <= {squared_sum[SUM_W-HI_W-1:0], {SCALE_W{1'b0}}};
      divisor <= {pixel_count, 1'b0} + {2'b00, pixel_count};
      quot    <= '0;
      seen    <= pixel_count;
    end else if (cmd.div_step) begin
      rem    <= fits ? (trial - {1'b0, divisor}) : trial;
      dvd_lo <= {dvd_lo[ERR_W-2:0], 1'b0};
      quot   <= {quot[ERR_W-2:0], fits};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      result.error_value <= (divisor == '0) ? '0 : quot;
      result.pixels_seen <= seen;
    end
  end

  `IMSE_ASSERT_NEXT(a_start_clears_acc, clk, rst, cmd.div_start,
                    squared_sum == '0 && pixel_count == '0)
  `IMSE_ASSERT_NOW(a_count_capped, clk, rst, 1'b1, pixel_count <= MAX_PIXELS)

endmodule

`default_nettype wire

[sv/image_mean_squared_error.sv]
// ----------------------------------------------------------------------------
// image_mean_squared_error
// Normalized mean squared error of an RGB test image against a reference.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+------------------------------
//   pixel    | pixel_valid / pixel_stall  | pixel_pair_t, one pixel pair
//   result   | result_valid / result_stall| mse_result_t, one per image
//
// Pixel pairs are taken one per cycle while an image streams in. A transfer
// with last_pixel set closes the image: pixel_stall then stays high for 27
// cycles (one to finish accumulating, one to load the divider, 24 for the
// restoring divider that produces one quotient bit per cycle, one to load
// the output register), plus any cycles the result must wait for a full
// output register to drain. Reset is synchronous and clears the sum, the
// count, the sequencer and the result valid flag. A stalled result holds
// in the output register while the next image is already accepted.
//
// The error is floor(sum * 256 / (3 * count)), with the sum of squared
// channel differences held in 42 bits. Once 2^24 pixels have been counted
// further pixels of the same image are ignored.
//
`default_nettype none

module image_mean_squared_error
  import imse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pixel_valid,
  output      logic        pixel_stall,
  input  wire pixel_pair_t pixel,
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      mse_result_t result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       pixel_ready;

  // The sequencer only raises ready in its intake state, so the stall seen
  // by the source is simply the inverse of that.
  assign pixel_stall = !pixel_ready;

  imse_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_last  (pixel.last_pixel),
    .status      (status),
    .cmd         (cmd),
    .pixel_ready (pixel_ready)
  );

  imse_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pixel        (pixel),
    .result_stall (result_stall),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire
